/* hdl/gdz_pkg.sv */
// ---------------------------------------------------------------------------
// gdz_pkg
// Types and constants shared by the gamepad dead-zone conditioner.
// ---------------------------------------------------------------------------
package gdz_pkg;

    localparam int unsigned STICK_FS   = 32767;
    localparam int unsigned TRIG_FS    = 255;
    localparam int unsigned OUT_ONE    = 32767;

    localparam int unsigned ISQRT_BITS = 16;
    localparam int unsigned DIV_QW     = 16;

    localparam int unsigned STK_NUM_W  = 46;
    localparam int unsigned STK_DEN_W  = 31;
    localparam int unsigned TRG_NUM_W  = 23;
    localparam int unsigned TRG_DEN_W  = 8;

    // stick front end: abs, two squares, sum, root, two product stages
    localparam int unsigned FRONT_LAT  = 3 + ISQRT_BITS + 2;

    typedef enum logic [1:0] {
        CFG_STICK_DZ = 2'd0,
        CFG_TRIG_DZ  = 2'd1
    } cfg_idx_e;

    typedef struct packed {
        logic               read_ok;
        logic [15:0]        button_word;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic [7:0]         left_trigger;
        logic [7:0]         right_trigger;
    } in_item_t;

    typedef struct packed {
        logic               connected;
        logic [13:0]        buttons_pressed;
        logic signed [15:0] left_x_out;
        logic signed [15:0] left_y_out;
        logic signed [15:0] right_x_out;
        logic signed [15:0] right_y_out;
        logic [14:0]        left_trigger_out;
        logic [14:0]        right_trigger_out;
    } out_item_t;

    typedef struct packed {
        logic                 active;
        logic                 neg_x;
        logic                 neg_y;
        logic [STK_NUM_W-1:0] numer_x;
        logic [STK_NUM_W-1:0] numer_y;
        logic [STK_DEN_W-1:0] den;
    } stick_front_t;

    typedef struct packed {
        logic                 active;
        logic [TRG_NUM_W-1:0] numer;
        logic [TRG_DEN_W-1:0] den;
    } trig_front_t;

    typedef struct packed {
        logic        valid;
        logic        read_ok;
        logic [13:0] buttons;
    } item_info_t;

    // output bit i comes from raw button bit BUTTON_SRC[i]
    typedef logic [3:0] btn_src_t [14];
    localparam btn_src_t BUTTON_SRC = '{
        4'd12, 4'd13, 4'd14, 4'd15, 4'd0, 4'd1, 4'd2, 4'd3,
        4'd8, 4'd9, 4'd6, 4'd7, 4'd4, 4'd5
    };

    function automatic logic [13:0] map_buttons(input logic [15:0] bw);
        logic [13:0] res;
        for (int i = 0; i < 14; i++)
        begin
            res[i] = bw[BUTTON_SRC[i]];
        end
        return res;
    endfunction

endpackage

/* hdl/gdz_delay.sv */
// ---------------------------------------------------------------------------
// gdz_delay
// Fixed-length shift line that keeps side data aligned with the datapath.
// ---------------------------------------------------------------------------
module gdz_delay #(
    parameter int unsigned W = 8,
    parameter int unsigned N = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                tap_reg[i] <= '0;
            end
        end
        else
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < N; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[N-1];

endmodule

/* hdl/gdz_isqrt.sv */
// ---------------------------------------------------------------------------
// gdz_isqrt
// Pipelined integer square root, one root bit per stage, with side data.
// ---------------------------------------------------------------------------
module gdz_isqrt #(
    parameter int unsigned RW   = 16,
    parameter int unsigned SB_W = 8
) (
    input  logic            clk,
    input  logic [2*RW-1:0] radicand,
    input  logic [SB_W-1:0] side_in,
    output logic [RW-1:0]   root,
    output logic [SB_W-1:0] side_out
);

    localparam int unsigned VW = 2*RW + 1;

    logic [RW-1:0]   root_reg [RW];
    logic [VW-1:0]   rem_reg  [RW];
    logic [SB_W-1:0] side_reg [RW];

    genvar k;
    generate
        for (k = 0; k < RW; k++)
        begin : g_stage
            localparam int unsigned B = RW - 1 - k;
            logic [RW-1:0]   r_in;
            logic [VW-1:0]   v_in;
            logic [SB_W-1:0] s_in;
            logic [VW-1:0]   trial;

            if (k == 0)
            begin : g_first
                assign r_in = '0;
                assign v_in = VW'(radicand);
                assign s_in = side_in;
            end
            else
            begin : g_next
                assign r_in = root_reg[k-1];
                assign v_in = rem_reg[k-1];
                assign s_in = side_reg[k-1];
            end

            // (r + 2^b)^2 - r^2
            assign trial = (VW'(r_in) << (B + 1)) + (VW'(1) << (2*B));

            always_ff @(posedge clk)
            begin
                if (v_in >= trial)
                begin
                    rem_reg[k]  <= v_in - trial;
                    root_reg[k] <= r_in | (RW'(1) << B);
                end
                else
                begin
                    rem_reg[k]  <= v_in;
                    root_reg[k] <= r_in;
                end
                side_reg[k] <= s_in;
            end
        end
    endgenerate

    assign root     = root_reg[RW-1];
    assign side_out = side_reg[RW-1];

endmodule

/* hdl/gdz_div.sv */
// ---------------------------------------------------------------------------
// gdz_div
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module gdz_div #(
    parameter int unsigned NUM_W = 16,
    parameter int unsigned DEN_W = 8,
    parameter int unsigned Q_W   = 8
) (
    input  logic             clk,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quot
);

    localparam int unsigned RW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [RW-1:0]    rem_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]   q_reg   [Q_W];

    genvar k;
    generate
        for (k = 0; k < Q_W; k++)
        begin : g_stage
            localparam int unsigned B = Q_W - 1 - k;
            logic [RW-1:0]    r_in;
            logic [DEN_W-1:0] d_in;
            logic [Q_W-1:0]   q_in;
            logic [RW-1:0]    shifted;

            if (k == 0)
            begin : g_first
                assign r_in = RW'(numer);
                assign d_in = den;
                assign q_in = '0;
            end
            else
            begin : g_next
                assign r_in = rem_reg[k-1];
                assign d_in = den_reg[k-1];
                assign q_in = q_reg[k-1];
            end

            assign shifted = RW'(d_in) << B;

            always_ff @(posedge clk)
            begin
                if (r_in >= shifted)
                begin
                    rem_reg[k] <= r_in - shifted;
                    q_reg[k]   <= q_in | (Q_W'(1) << B);
                end
                else
                begin
                    rem_reg[k] <= r_in;
                    q_reg[k]   <= q_in;
                end
                den_reg[k] <= d_in;
            end
        end
    endgenerate

    assign quot = q_reg[Q_W-1];

endmodule

/* hdl/gdz_stick.sv */
// ---------------------------------------------------------------------------
// gdz_stick
// Stick front end: magnitude, clamp and the numerators and divisor of the
// radial rescale.
// ---------------------------------------------------------------------------
module gdz_stick
    import gdz_pkg::*;
(
    input  logic               clk,
    input  logic signed [15:0] x,
    input  logic signed [15:0] y,
    input  logic [14:0]        dead_zone,
    output stick_front_t       front
);

    logic [15:0] ax_reg, ay_reg, ax2_reg, ay2_reg, ax3_reg, ay3_reg;
    logic        nx_reg, ny_reg, nx2_reg, ny2_reg, nx3_reg, ny3_reg;
    logic [31:0] sqx_reg, sqy_reg, sum_reg;

    always_ff @(posedge clk)
    begin
        ax_reg  <= x[15] ? 16'(-x) : 16'(x);
        ay_reg  <= y[15] ? 16'(-y) : 16'(y);
        nx_reg  <= x[15];
        ny_reg  <= y[15];
        sqx_reg <= ax_reg * ax_reg;
        sqy_reg <= ay_reg * ay_reg;
        ax2_reg <= ax_reg;
        ay2_reg <= ay_reg;
        nx2_reg <= nx_reg;
        ny2_reg <= ny_reg;
        sum_reg <= sqx_reg + sqy_reg;
        ax3_reg <= ax2_reg;
        ay3_reg <= ay2_reg;
        nx3_reg <= nx2_reg;
        ny3_reg <= ny2_reg;
    end

    logic [15:0] mag;
    logic [33:0] side_out;

    gdz_isqrt #(
        .RW   (ISQRT_BITS),
        .SB_W (34)
    ) u_isqrt (
        .clk      (clk),
        .radicand (sum_reg),
        .side_in  ({nx3_reg, ny3_reg, ax3_reg, ay3_reg}),
        .root     (mag),
        .side_out (side_out)
    );

    logic [15:0] ax_s, ay_s;
    logic        nx_s, ny_s;
    logic [14:0] clamped, num, fs_dz;
    logic        active;

    assign {nx_s, ny_s, ax_s, ay_s} = side_out;
    assign clamped = (mag < 16'(STICK_FS)) ? mag[14:0] : 15'(STICK_FS);
    assign num     = clamped - dead_zone;
    assign fs_dz   = 15'(STICK_FS) - dead_zone;
    assign active  = (dead_zone < 15'(STICK_FS)) && (mag > 16'(dead_zone));

    logic [30:0] px_reg, py_reg, den_reg;
    logic        act_reg, nxm_reg, nym_reg;

    always_ff @(posedge clk)
    begin
        px_reg  <= ax_s * num;
        py_reg  <= ay_s * num;
        den_reg <= mag * fs_dz;
        act_reg <= active;
        nxm_reg <= nx_s;
        nym_reg <= ny_s;
    end

    stick_front_t front_reg;

    // times 32767 as shift and subtract
    always_ff @(posedge clk)
    begin
        front_reg.active  <= act_reg;
        front_reg.neg_x   <= nxm_reg;
        front_reg.neg_y   <= nym_reg;
        front_reg.numer_x <= {px_reg, 15'd0} - STK_NUM_W'(px_reg);
        front_reg.numer_y <= {py_reg, 15'd0} - STK_NUM_W'(py_reg);
        front_reg.den     <= den_reg;
    end

    assign front = front_reg;

endmodule

/* hdl/gamepad_dead_zone_conditioner_top.sv */
// ---------------------------------------------------------------------------
// gamepad_dead_zone_conditioner_top
// Controller report conditioning: radial stick dead zones, trigger dead zones
// and button remapping.
// ---------------------------------------------------------------------------
// One report is taken every clock cycle (busy stays low) and its result shows
// on result with done high for one cycle. The path runs through the input
// stage, the 16-stage square root of each stick's magnitude, the 16-stage
// dividers of the rescale that follows and the output register; the results
// come out in order, and there is no way to hold them back.
module gamepad_dead_zone_conditioner_top
    import gdz_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_item_t    item,
    output logic        done,
    output out_item_t   result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data
);

    localparam int unsigned INFO_LAT = FRONT_LAT + DIV_QW;

    logic [14:0] stick_dz_reg;
    logic [7:0]  trig_dz_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stick_dz_reg <= 15'd7864;
            trig_dz_reg  <= 8'd30;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_STICK_DZ: stick_dz_reg <= cfg_data;
                CFG_TRIG_DZ:  trig_dz_reg  <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    // input stage
    in_item_t   in_reg;
    item_info_t info_reg;

    always_ff @(posedge clk)
    begin
        in_reg <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            info_reg <= '0;
        end
        else
        begin
            info_reg.valid   <= start && !busy;
            info_reg.read_ok <= item.read_ok;
            info_reg.buttons <= map_buttons(item.button_word);
        end
    end

    item_info_t info_end;

    gdz_delay #(
        .W ($bits(item_info_t)),
        .N (INFO_LAT)
    ) u_info_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (info_reg),
        .dout  (info_end)
    );

    // sticks
    stick_front_t lf, rf;

    gdz_stick u_left (
        .clk       (clk),
        .x         (in_reg.left_x),
        .y         (in_reg.left_y),
        .dead_zone (stick_dz_reg),
        .front     (lf)
    );

    gdz_stick u_right (
        .clk       (clk),
        .x         (in_reg.right_x),
        .y         (in_reg.right_y),
        .dead_zone (stick_dz_reg),
        .front     (rf)
    );

    // triggers
    trig_front_t lt_reg, rt_reg, lt_al, rt_al;

    function automatic trig_front_t trig_prep(input logic [7:0] v, input logic [7:0] dz);
        trig_front_t t;
        logic [7:0]  vc;
        logic [7:0]  diff;
        vc       = (v > 8'(TRIG_FS)) ? 8'(TRIG_FS) : v;
        diff     = vc - dz;
        t.active = (dz < 8'(TRIG_FS)) && (v > dz);
        t.numer  = {diff, 15'd0} - TRG_NUM_W'(diff);
        t.den    = 8'(TRIG_FS) - dz;
        return t;
    endfunction

    always_ff @(posedge clk)
    begin
        lt_reg <= trig_prep(in_reg.left_trigger, trig_dz_reg);
        rt_reg <= trig_prep(in_reg.right_trigger, trig_dz_reg);
    end

    gdz_delay #(
        .W (2*$bits(trig_front_t)),
        .N (FRONT_LAT - 1)
    ) u_trig_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .din   ({lt_reg, rt_reg}),
        .dout  ({lt_al, rt_al})
    );

    // dividers
    logic [DIV_QW-1:0] q_lx, q_ly, q_rx, q_ry, q_lt, q_rt;

    gdz_div #(.NUM_W(STK_NUM_W), .DEN_W(STK_DEN_W), .Q_W(DIV_QW)) u_div_lx
        (.clk(clk), .numer(lf.numer_x), .den(lf.den), .quot(q_lx));
    gdz_div #(.NUM_W(STK_NUM_W), .DEN_W(STK_DEN_W), .Q_W(DIV_QW)) u_div_ly
        (.clk(clk), .numer(lf.numer_y), .den(lf.den), .quot(q_ly));
    gdz_div #(.NUM_W(STK_NUM_W), .DEN_W(STK_DEN_W), .Q_W(DIV_QW)) u_div_rx
        (.clk(clk), .numer(rf.numer_x), .den(rf.den), .quot(q_rx));
    gdz_div #(.NUM_W(STK_NUM_W), .DEN_W(STK_DEN_W), .Q_W(DIV_QW)) u_div_ry
        (.clk(clk), .numer(rf.numer_y), .den(rf.den), .quot(q_ry));
    gdz_div #(.NUM_W(TRG_NUM_W), .DEN_W(TRG_DEN_W), .Q_W(DIV_QW)) u_div_lt
        (.clk(clk), .numer(lt_al.numer), .den(lt_al.den), .quot(q_lt));
    gdz_div #(.NUM_W(TRG_NUM_W), .DEN_W(TRG_DEN_W), .Q_W(DIV_QW)) u_div_rt
        (.clk(clk), .numer(rt_al.numer), .den(rt_al.den), .quot(q_rt));

    // flags that ride alongside the dividers
    logic [5:0] flags_end;

    gdz_delay #(
        .W (6),
        .N (DIV_QW)
    ) u_flag_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .din   ({lf.active, lf.neg_x, lf.neg_y, rf.active, rf.neg_x, rf.neg_y}),
        .dout  (flags_end)
    );

    logic [1:0] trig_act_end;

    gdz_delay #(
        .W (2),
        .N (DIV_QW)
    ) u_tact_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .din   ({lt_al.active, rt_al.active}),
        .dout  (trig_act_end)
    );

    function automatic logic [14:0] sat15(input logic [DIV_QW-1:0] q);
        return (q > DIV_QW'(OUT_ONE)) ? 15'(OUT_ONE) : q[14:0];
    endfunction

    function automatic logic [15:0] axis_out(input logic act, input logic neg,
                                             input logic [DIV_QW-1:0] q);
        logic [15:0] mag;
        mag = {1'b0, sat15(q)};
        if (!act)
        begin
            return '0;
        end
        return neg ? 16'(-mag) : mag;
    endfunction

    out_item_t result_next, result_reg;
    logic      done_reg;

    always_comb
    begin
        result_next = '0;
        if (info_end.read_ok)
        begin
            result_next.connected         = 1'b1;
            result_next.buttons_pressed   = info_end.buttons;
            result_next.left_x_out        = axis_out(flags_end[5], flags_end[4], q_lx);
            result_next.left_y_out        = axis_out(flags_end[5], flags_end[3], q_ly);
            result_next.right_x_out       = axis_out(flags_end[2], flags_end[1], q_rx);
            result_next.right_y_out       = axis_out(flags_end[2], flags_end[0], q_ry);
            result_next.left_trigger_out  = trig_act_end[1] ? sat15(q_lt) : 15'd0;
            result_next.right_trigger_out = trig_act_end[0] ? sat15(q_rt) : 15'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= info_end.valid;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // every result traces back to an item taken a fixed time earlier
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, INFO_LAT + 2))
        else $error("result without a matching item");

    // a failed read gives an all-zero result
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.connected) |-> (result == '0))
        else $error("failed read gave nonzero fields");

    // dead zone registers only move on a config write
    a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_valid && cfg_ready) |=> ($stable(stick_dz_reg) && $stable(trig_dz_reg)))
        else $error("dead zone changed without a write");

endmodule
